@@ hw/rtl/bam_pkg.sv @@
// Shared types, constants and helpers for the approximate bitap matcher.
// No dependencies; every other file of the block imports this package.
package bam_pkg;

	// Field widths of the channels.
	localparam int CMD_W = 2;
	localparam int POS_W = 5;
	localparam int CHAR_W = 8;
	localparam int LEN_W = 6;
	localparam int ERR_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 6;

	// Size of the character mask table: one entry per 8-bit code.
	localparam int ALPHABET = 256;

	// Depth of the result queue in front of the output channel.
	localparam int OUT_DEPTH = 3;
	localparam int OUT_CNT_W = 2;
	localparam int OUT_PTR_W = 2;

	// Item commands.
	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_TEXT  = 2'd2
	} cmd_t;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_COUNT = 2'd1;

	// Item held in the lookup stage.
	typedef struct packed {
		logic              valid;
		logic [CMD_W-1:0]  cmd;
		logic              last;
		logic [POS_W-1:0]  position;
		logic [CHAR_W-1:0] addr;
	} op_t;

	// Upper-case ASCII letters a..z; every other code passes unchanged.
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c >= 8'h61 && c <= 8'h7A) begin
			r = c - 8'h20;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/bam_ifs.sv @@
// Valid/ready channel interfaces of the approximate bitap matcher.
// Depends on bam_pkg for the field widths.
interface bam_in_if;
	import bam_pkg::*;
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [POS_W-1:0]  position;
	logic [CHAR_W-1:0] char_code;
	logic              last_of_string;
	modport source(output valid, command, position, char_code, last_of_string, input ready);
	modport sink(input valid, command, position, char_code, last_of_string, output ready);
endinterface

interface bam_out_if;
	logic valid;
	logic ready;
	logic matched;
	modport source(output valid, matched, input ready);
	modport sink(input valid, matched, output ready);
endinterface

interface bam_cfg_if;
	import bam_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

@@ hw/rtl/approximate_bitap_matcher.sv @@
// Top level of the approximate bitap matcher (shift-and with k edit errors).
// Depends on bam_pkg, bam_ifs, bam_mask_mem, bam_level_unit, bam_out_fifo.
//
// Channel     Dir  Payload                                       Transfer
// item_in     in   command, position, char_code, last_of_string  valid & ready
// result_out  out  matched                                       valid & ready
// cfg         in   index (0 pattern_length, 1 error_count), data valid & ready
//
// One item per cycle is taken unless input stalls; the mask table is read as the
// item enters the lookup stage, and each result is registered in the queue.
// The mask table clear resets all per-entry valid bits at once.
// Loads and text bytes may follow each other freely; the table forwards writes.
// A three-entry result queue lets input continue while results wait; input
// stalls only when that queue and the lookup stage could not take one more.
// Reset is asynchronous, active low, and needs no clearing pass.
module approximate_bitap_matcher #(
	parameter int MAX_PATTERN = 32,
	parameter int MAX_LEVELS = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	bam_in_if.sink    item_in,
	bam_out_if.source result_out,
	bam_cfg_if.sink   cfg
);
	import bam_pkg::*;

	logic                 accept;
	op_t                  op_s1;
	logic [LEN_W-1:0]     pattern_length_q;
	logic [ERR_W-1:0]     error_count_q;
	logic [MAX_PATTERN-1:0] eff_mask;
	logic                 push;
	logic                 push_data;
	logic [OUT_CNT_W-1:0] out_count;
	logic [OUT_CNT_W:0]   committed;

	// Room check: queued results plus a possible result from the lookup stage.
	assign committed = {1'b0, out_count} + (OUT_CNT_W + 1)'(push);
	assign item_in.ready = (committed <= (OUT_CNT_W + 1)'(OUT_DEPTH - 1));
	assign accept = item_in.valid && item_in.ready;
	assign cfg.ready = 1'b1;

	// Lookup stage register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
		end else begin
			op_s1.valid <= accept;
			if (accept) begin
				op_s1.cmd <= item_in.command;
				op_s1.last <= item_in.last_of_string;
				op_s1.position <= item_in.position;
				op_s1.addr <= fold_case(item_in.char_code);
			end
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= LEN_W'(1);
			error_count_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PATTERN_LENGTH: pattern_length_q <= cfg.data[LEN_W-1:0];
				REG_ERROR_COUNT: error_count_q <= cfg.data[ERR_W-1:0];
				default: ;
			endcase
		end
	end

	bam_mask_mem #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_mask (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (fold_case(item_in.char_code)),
		.op      (op_s1),
		.eff_mask(eff_mask)
	);

	bam_level_unit #(
		.MAX_PATTERN(MAX_PATTERN),
		.MAX_LEVELS (MAX_LEVELS)
	) u_levels (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op_s1),
		.mask          (eff_mask),
		.pattern_length(pattern_length_q),
		.error_count   (error_count_q),
		.push          (push),
		.matched       (push_data)
	);

	bam_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.out_ch   (result_out),
		.count    (out_count)
	);

	// An accepted item always finds room for its result in the following cycle.
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (out_count < OUT_CNT_W'(OUT_DEPTH)) || (result_out.valid && result_out.ready)
			|| !push)
		else $error("accepted item without room for its result");

	// Every lookup-stage item was accepted the cycle before.
	a_stage: assert property (@(posedge clk) disable iff (!arst_n)
		op_s1.valid |-> $past(accept))
		else $error("lookup stage holds an item that was not accepted");

	// Results come only from text bytes that end a string.
	a_push_src: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (op_s1.cmd == CMD_TEXT) && op_s1.last)
		else $error("result pushed for a non-final item");

endmodule

@@ hw/rtl/bam_mask_mem.sv @@
// Character mask table: synchronous memory with per-entry valid bits,
// read-modify-write for pattern loads and forwarding from the lookup stage.
// Depends on bam_pkg.
module bam_mask_mem #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bam_pkg::CHAR_W-1:0] rd_addr,
	input  bam_pkg::op_t              op,
	output logic [MAX_PATTERN-1:0]    eff_mask
);
	import bam_pkg::*;

	logic [MAX_PATTERN-1:0] mem [ALPHABET];
	logic [ALPHABET-1:0]    vbit_q;
	logic [MAX_PATTERN-1:0] rdata_q;
	logic                   rvalid_q;
	logic                   fwd_hit_q;
	logic [MAX_PATTERN-1:0] fwd_data_q;
	logic [MAX_PATTERN-1:0] load_bit;
	logic [MAX_PATTERN-1:0] wdata;
	logic                   op_clear;
	logic                   op_load;

	assign op_clear = op.valid && (op.cmd == CMD_CLEAR);
	assign op_load = op.valid && (op.cmd == CMD_LOAD);

	// One-hot bit of the load position; positions past the vector set nothing.
	always_comb begin
		for (int j = 0; j < MAX_PATTERN; j++) begin
			load_bit[j] = (7'(j) == {2'b00, op.position});
		end
	end

	// Mask seen by the item in the lookup stage: forwarded data wins over the
	// memory read, and an entry never written since the last clear reads as zero.
	always_comb begin
		if (fwd_hit_q) begin
			eff_mask = fwd_data_q;
		end else if (rvalid_q) begin
			eff_mask = rdata_q;
		end else begin
			eff_mask = '0;
		end
	end

	assign wdata = eff_mask | load_bit;

	// Memory array: write-back of loads and registered read.
	always_ff @(posedge clk) begin
		if (op_load) begin
			mem[op.addr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
		fwd_data_q <= op_clear ? '0 : wdata;
	end

	// Valid bits and forwarding flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q <= '0;
			rvalid_q <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			rvalid_q <= vbit_q[rd_addr];
			fwd_hit_q <= op_clear || (op_load && (op.addr == rd_addr));
			if (op_clear) begin
				vbit_q <= '0;
			end else if (op_load) begin
				vbit_q[op.addr] <= 1'b1;
			end
		end
	end

	// A clear is seen by the very next item in the lookup stage.
	a_clear_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		op_clear |=> (eff_mask == '0))
		else $error("mask lookup after clear is not zero");

	// A load to the same entry is seen by the next lookup.
	a_load_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(op_load && op.addr == rd_addr) |=> ((eff_mask & $past(load_bit)) == $past(load_bit)))
		else $error("back-to-back load not forwarded");

	// After a clear every entry reads as invalid.
	a_clear_vbit: assert property (@(posedge clk) disable iff (!arst_n)
		op_clear |=> (vbit_q == '0))
		else $error("valid bits survive a clear");

endmodule

@@ hw/rtl/bam_level_unit.sv @@
// Error-level bit vectors and sticky match flag of the bitap matcher.
// Updates the active levels for one text byte per cycle. Depends on bam_pkg.
module bam_level_unit #(
	parameter int MAX_PATTERN = 32,
	parameter int MAX_LEVELS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  bam_pkg::op_t              op,
	input  logic [MAX_PATTERN-1:0]    mask,
	input  logic [bam_pkg::LEN_W-1:0] pattern_length,
	input  logic [bam_pkg::ERR_W-1:0] error_count,
	output logic                      push,
	output logic                      matched
);
	import bam_pkg::*;

	logic [MAX_PATTERN-1:0] lvl_q [MAX_LEVELS];
	logic [MAX_PATTERN-1:0] lvl_new [MAX_LEVELS];
	logic [MAX_PATTERN-1:0] lvl_init [MAX_LEVELS];
	logic [MAX_LEVELS-1:0]  active;
	logic [MAX_PATTERN-1:0] hit_vec;
	logic [6:0]             len_eff;
	logic                   match_seen_q;
	logic                   any_hit;
	logic                   is_text;

	assign is_text = op.valid && (op.cmd == CMD_TEXT);
	assign push = is_text && op.last;

	// Level i restarts as 2^i-1, cut to the vector width.
	always_comb begin
		for (int i = 0; i < MAX_LEVELS; i++) begin
			for (int j = 0; j < MAX_PATTERN; j++) begin
				lvl_init[i][j] = (j < i);
			end
			active[i] = (5'(i) <= {2'b00, error_count});
		end
	end

	// Effective pattern length and the match bit it selects.
	always_comb begin
		len_eff = {1'b0, pattern_length};
		if (len_eff == 7'd0) begin
			len_eff = 7'd1;
		end else if (len_eff > 7'(MAX_PATTERN)) begin
			len_eff = 7'(MAX_PATTERN);
		end
		for (int j = 0; j < MAX_PATTERN; j++) begin
			hit_vec[j] = (len_eff == 7'(j + 1));
		end
	end

	// Shift-and step for level 0, then insert/delete/substitute chain upward.
	always_comb begin
		lvl_new[0] = ((lvl_q[0] << 1) | MAX_PATTERN'(1)) & mask;
		any_hit = |(lvl_new[0] & hit_vec);
		for (int i = 1; i < MAX_LEVELS; i++) begin
			lvl_new[i] = MAX_PATTERN'(1)
				| ((lvl_q[i-1] | lvl_new[i-1]) << 1)
				| ((lvl_q[i] << 1) & mask)
				| lvl_q[i-1];
			if (active[i] && |(lvl_new[i] & hit_vec)) begin
				any_hit = 1'b1;
			end
		end
	end

	assign matched = match_seen_q | any_hit;

	// Level vectors and sticky flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				lvl_q[i] <= lvl_init[i];
			end
			match_seen_q <= 1'b0;
		end else if (is_text) begin
			for (int i = 0; i < MAX_LEVELS; i++) begin
				if (op.last) begin
					lvl_q[i] <= lvl_init[i];
				end else if (active[i]) begin
					lvl_q[i] <= lvl_new[i];
				end
			end
			match_seen_q <= op.last ? 1'b0 : (match_seen_q | any_hit);
		end
	end

	// The end of a string restarts level 0 empty and drops the flag.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> (lvl_q[0] == '0) && !match_seen_q)
		else $error("levels not restarted after end of string");

	// The flag only rises on a text byte that hit the match bit.
	a_flag_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(match_seen_q) |-> $past(is_text && any_hit))
		else $error("match flag rose without a hit");

	// Only text bytes move the level vectors.
	a_levels_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!is_text |=> $stable(lvl_q[0]))
		else $error("level vector changed without a text byte");

endmodule

@@ hw/rtl/bam_out_fifo.sv @@
// Small result queue that drives the output channel from registers.
// Depends on bam_pkg and bam_out_if.
module bam_out_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          push_data,
	bam_out_if.source                     out_ch,
	output logic [bam_pkg::OUT_CNT_W-1:0] count
);
	import bam_pkg::*;

	logic                 data_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_CNT_W-1:0] count_q;
	logic                 pop;

	assign pop = out_ch.valid && out_ch.ready;
	assign out_ch.valid = (count_q != '0);
	assign out_ch.matched = data_q[rd_ptr_q];
	assign count = count_q;

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			data_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == OUT_PTR_W'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Never push into a full queue.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < OUT_CNT_W'(OUT_DEPTH)) || pop)
		else $error("result queue overflow");

	// Fill level tracks pushes and pops.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("result queue count mismatch");

	// Pointers stay inside the queue.
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_ptr_q < OUT_PTR_W'(OUT_DEPTH)) && (wr_ptr_q < OUT_PTR_W'(OUT_DEPTH)))
		else $error("result queue pointer out of range");

endmodule

@@ dv/approximate_bitap_matcher_test.sv @@
`timescale 1ns / 100ps
// Self-checking bench for the approximate bitap matcher: drives items, register writes and
// result back-pressure, and checks every match flag against a cycle-free behavioral tracker.
// Depends on bam_pkg, the channel interfaces in bam_ifs and the approximate_bitap_matcher RTL.
module approximate_bitap_matcher_test;
	import bam_pkg::*;

	localparam int PAT_BITS = 32;
	localparam int LEVELS = 8;
	localparam int ITEM_GOAL = 1800;
	localparam int LONG_HOLD = 300;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

	// Behavioral tracker: mask table, error-level vectors and the sticky flag of the block.
	class bitap_tracker;
		logic [PAT_BITS-1:0] char_masks [ALPHABET];
		logic [PAT_BITS-1:0] err_vecs [LEVELS];
		bit seen;
		logic [LEN_W-1:0] len_reg;
		logic [ERR_W-1:0] err_reg;
		bit flags_due [$];
		int mismatch_count;
		int results_seen;
		int hits_seen;

		function new();
			foreach (char_masks[i]) char_masks[i] = '0;
			reload();
			seen = 1'b0;
			len_reg = 6'd1;
			err_reg = 3'd0;
			mismatch_count = 0;
			results_seen = 0;
			hits_seen = 0;
		endfunction

		// Level i restarts with its i lowest bits set.
		function void reload();
			for (int i = 0; i < LEVELS; i++) begin
				err_vecs[i] = (32'd1 << i) - 32'd1;
			end
		endfunction

		function logic [CHAR_W-1:0] upper(logic [CHAR_W-1:0] c);
			if (c >= 8'h61 && c <= 8'h7A) begin
				return c - 8'h20;
			end
			return c;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			if (idx == REG_PATTERN_LENGTH) begin
				len_reg = value[LEN_W-1:0];
			end else if (idx == REG_ERROR_COUNT) begin
				err_reg = value[ERR_W-1:0];
			end
		endfunction

		// Applies one accepted item and queues the flag that a closing text byte produces.
		function void note_item(logic [CMD_W-1:0] cmd, logic [POS_W-1:0] pos,
				logic [CHAR_W-1:0] code, logic last);
			logic [PAT_BITS-1:0] lookup, hit, prev_old, prev_new, old_v, nxt;
			int eff, lvls;
			if (cmd == CMD_CLEAR) begin
				foreach (char_masks[i]) char_masks[i] = '0;
			end else if (cmd == CMD_LOAD) begin
				char_masks[upper(code)] |= 32'd1 << pos;
			end else if (cmd == CMD_TEXT) begin
				eff = int'(len_reg);
				if (eff == 0) eff = 1;
				if (eff > PAT_BITS) eff = PAT_BITS;
				lvls = int'(err_reg) + 1;
				if (lvls > LEVELS) lvls = LEVELS;
				hit = 32'd1 << (eff - 1);
				lookup = char_masks[upper(code)];

				// Exact level first, then each error level from its neighbor below.
				prev_old = err_vecs[0];
				err_vecs[0] = ((prev_old << 1) | 32'd1) & lookup;
				prev_new = err_vecs[0];
				if ((prev_new & hit) != 0) seen = 1'b1;
				for (int i = 1; i < lvls; i++) begin
					old_v = err_vecs[i];
					nxt = 32'd1 | ((prev_old | prev_new) << 1) | ((old_v << 1) & lookup)
						| prev_old;
					err_vecs[i] = nxt;
					if ((nxt & hit) != 0) seen = 1'b1;
					prev_old = old_v;
					prev_new = nxt;
				end

				if (last) begin
					flags_due = {flags_due, seen};
					seen = 1'b0;
					reload();
				end
			end
		endfunction

		function int pending();
			return flags_due.size();
		endfunction

		task log_mismatch(string msg);
			mismatch_count++;
			if (mismatch_count <= 100) begin
				$display("[%0t] MISMATCH: %s", $time, msg);
			end
		endtask

		// Compares one transferred result with the oldest outstanding flag.
		task check_flag(logic matched);
			bit want;
			results_seen++;
			if (flags_due.size() == 0) begin
				log_mismatch($sformatf("matched=%0b arrived with no result outstanding",
					matched));
			end else begin
				want = flags_due.pop_front();
				if (want) hits_seen++;
				if (matched !== want) begin
					log_mismatch($sformatf("matched=%0b, predicted %0b", matched, want));
				end
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	bam_in_if item_ch ();
	bam_out_if result_ch ();
	bam_cfg_if cfg_ch ();

	approximate_bitap_matcher u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_ch),
		.result_out(result_ch),
		.cfg(cfg_ch)
	);

	bitap_tracker tracker = new();

	int items_sent = 0;
	int cfg_writes = 0;
	int settings_used = 0;
	int src_mode = 0;
	int sink_mode = 1;
	int hold_request = 0;
	logic [CHAR_W-1:0] pat [PAT_BITS];

	// Clock generation.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Overall time limit.
	initial begin
		#8_000_000;
		$display("approximate_bitap_matcher regression: fail");
		$finish;
	end

	// Idle cycles before one transfer: none in mode 0, a random gap in the other modes.
	function automatic int draw_gap(int mode);
		if (mode == 0) return 0;
		if (mode == 1) return $urandom_range(0, 2);
		return $urandom_range(0, 18);
	endfunction

	// Mostly pattern letters, sometimes case-fold boundaries and arbitrary codes.
	function automatic logic [CHAR_W-1:0] pick_symbol();
		case ($urandom_range(0, 19))
			0, 1: return CHAR_W'($urandom_range(0, 255));
			2: return 8'h40;
			3: return 8'h5B;
			4: return 8'h60;
			5: return 8'h7B;
			6: return 8'hC1;
			default: return CHAR_W'(8'h41 + $urandom_range(0, 4));
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] vary_case(logic [CHAR_W-1:0] c);
		if (((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)) && $urandom_range(0, 1))
			return c ^ 8'h20;
		return c;
	endfunction

	function automatic logic [LEN_W-1:0] pick_length();
		case ($urandom_range(0, 11))
			0: return 6'd0;
			1: return 6'd32;
			2: return LEN_W'($urandom_range(33, 63));
			3: return 6'd1;
			4: return LEN_W'($urandom_range(9, 31));
			default: return LEN_W'($urandom_range(2, 8));
		endcase
	endfunction

	function automatic logic [ERR_W-1:0] pick_errors();
		case ($urandom_range(0, 7))
			0: return 3'd7;
			1: return ERR_W'($urandom_range(3, 6));
			2, 3: return 3'd0;
			default: return ERR_W'($urandom_range(1, 2));
		endcase
	endfunction

	// Offers one item and returns at the edge of its transfer.
	task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [CHAR_W-1:0] code, input logic last);
		int gap;
		gap = draw_gap(src_mode);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.command <= cmd;
		item_ch.position <= pos;
		item_ch.char_code <= code;
		item_ch.last_of_string <= last;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		tracker.note_item(cmd, pos, code, last);
		items_sent++;
	endtask

	// Stops offering items, waits for every outstanding flag, then lets the pipeline empty.
	task automatic wait_for_flags(input int limit);
		int n;
		n = 0;
		item_ch.valid <= 1'b0;
		while (tracker.pending() > 0 && n < limit) begin
			@(posedge clk);
			n++;
		end
		if (tracker.pending() > 0) begin
			tracker.log_mismatch($sformatf("%0d results never arrived", tracker.pending()));
		end
		repeat (4) @(posedge clk);
	endtask

	// Writes both registers once the block is idle.
	task automatic settle(input logic [LEN_W-1:0] plen, input logic [ERR_W-1:0] errs);
		wait_for_flags(4000);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_PATTERN_LENGTH;
		cfg_ch.data <= plen;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		tracker.set_reg(REG_PATTERN_LENGTH, plen);
		cfg_ch.index <= REG_ERROR_COUNT;
		cfg_ch.data <= {3'b000, errs};
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		tracker.set_reg(REG_ERROR_COUNT, {3'b000, errs});
		cfg_ch.valid <= 1'b0;
		cfg_writes += 2;
		settings_used++;
	endtask

	// Items that disturb a string: unused code, stray loads, a rare clear.
	task automatic send_noise();
		case ($urandom_range(0, 5))
			0, 1, 2: send_item(CMD_UNUSED, POS_W'($urandom_range(0, 31)),
				CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			3, 4: send_item(CMD_LOAD, POS_W'($urandom_range(0, 31)), pick_symbol(),
				1'($urandom_range(0, 1)));
			default: send_item(CMD_CLEAR, POS_W'($urandom_range(0, 31)),
				CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		endcase
	endtask

	// One string: the pattern with a few edits between random padding.
	task automatic send_string(input int eff, input bit mid_cfg);
		logic [CHAR_W-1:0] txt [$];
		int cut;
		repeat ($urandom_range(0, 3)) txt = {txt, pick_symbol()};
		if ($urandom_range(0, 3) != 0) begin
			for (int j = 0; j < eff; j++) begin
				case ($urandom_range(0, 15))
					0: ;
					1: txt = {txt, pick_symbol()};
					2: begin
						txt = {txt, vary_case(pat[j])};
						txt = {txt, pick_symbol()};
					end
					default: txt = {txt, vary_case(pat[j])};
				endcase
			end
		end
		repeat ($urandom_range(0, 3)) txt = {txt, pick_symbol()};
		if (txt.size() == 0) txt = {txt, pick_symbol()};
		cut = mid_cfg ? txt.size() / 2 : -1;
		for (int j = 0; j < txt.size(); j++) begin
			if ($urandom_range(0, 13) == 0) send_noise();
			// Register change while the string is open: levels and flag carry over.
			if (j == cut && j > 0) settle(pick_length(), pick_errors());
			send_item(CMD_TEXT, POS_W'($urandom_range(0, 31)), txt[j], j == txt.size() - 1);
		end
	endtask

	// Result side: random stalls, one long hold on request, and the check of each transfer.
	initial begin
		int gap, n;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				n = hold_request;
				hold_request = 0;
				result_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end else begin
				gap = draw_gap(sink_mode);
				if (gap > 0) begin
					result_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid && hold_request == 0) @(posedge clk);
			if (result_ch.valid) begin
				tracker.check_flag(result_ch.matched);
				if (tracker.results_seen % 40 == 0) sink_mode = $urandom_range(0, 2);
			end
		end
	end

	// Stimulus: reset, directed items, then random phases of configuration, pattern and text.
	initial begin
		int phase, eff, random_start, strings;
		logic [LEN_W-1:0] plen;
		logic [ERR_W-1:0] errs;
		arst_n <= 1'b0;
		item_ch.valid <= 1'b0;
		item_ch.command <= CMD_CLEAR;
		item_ch.position <= '0;
		item_ch.char_code <= '0;
		item_ch.last_of_string <= 1'b0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_PATTERN_LENGTH;
		cfg_ch.data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings, empty table, case folding, ignored commands and flags.
		src_mode = 1;
		send_item(CMD_TEXT, 5'd0, 8'h61, 1'b1);
		send_item(CMD_LOAD, 5'd0, 8'h61, 1'b0);
		send_item(CMD_LOAD, 5'd31, 8'hFF, 1'b1);
		send_item(CMD_TEXT, 5'd31, 8'h41, 1'b1);
		send_item(CMD_TEXT, 5'd0, 8'hE1, 1'b1);
		send_item(CMD_UNUSED, 5'd31, 8'hFF, 1'b1);
		send_item(CMD_TEXT, 5'd0, 8'hFF, 1'b1);
		send_item(CMD_CLEAR, 5'd31, 8'hFF, 1'b1);
		send_item(CMD_TEXT, 5'd0, 8'h61, 1'b1);

		// Zero length behaves as one; codes next to the letter ranges are not folded.
		settle(6'd0, 3'd0);
		send_item(CMD_LOAD, 5'd0, 8'h7B, 1'b0);
		send_item(CMD_TEXT, 5'd0, 8'h5B, 1'b1);
		send_item(CMD_TEXT, 5'd0, 8'h7B, 1'b1);
		send_item(CMD_LOAD, 5'd1, 8'h60, 1'b0);
		send_item(CMD_TEXT, 5'd0, 8'h40, 1'b1);

		// Oversized length saturates; a load inside a string applies at once.
		settle(6'd63, 3'd7);
		send_item(CMD_TEXT, 5'd0, 8'h7B, 1'b0);
		send_item(CMD_LOAD, 5'd5, 8'h7A, 1'b0);
		send_item(CMD_TEXT, 5'd0, 8'h5A, 1'b1);
		settle(6'd32, 3'd7);
		send_item(CMD_LOAD, 5'd16, 8'h00, 1'b0);
		send_item(CMD_TEXT, 5'd0, 8'h00, 1'b0);
		settle(6'd2, 3'd1);
		send_item(CMD_TEXT, 5'd0, 8'h80, 1'b0);
		send_item(CMD_TEXT, 5'd0, 8'h00, 1'b1);

		// Random phases; the first one runs against a long result stall.
		phase = 0;
		random_start = items_sent;
		while (items_sent - random_start < ITEM_GOAL) begin
			plen = (phase == 0) ? 6'd3 : pick_length();
			errs = (phase == 0) ? 3'd1 : pick_errors();
			settle(plen, errs);
			eff = (plen == 0) ? 1 : (plen > PAT_BITS) ? PAT_BITS : int'(plen);
			src_mode = $urandom_range(0, 2);
			if (phase == 0) begin
				hold_request = LONG_HOLD;
				src_mode = 0;
			end

			if ($urandom_range(0, 4) != 0) begin
				send_item(CMD_CLEAR, POS_W'($urandom_range(0, 31)),
					CHAR_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			end
			for (int j = 0; j < eff; j++) begin
				pat[j] = pick_symbol();
				send_item(CMD_LOAD, POS_W'(j), vary_case(pat[j]), 1'($urandom_range(0, 1)));
			end
			// Bits above the match bit are stored but never reach it.
			if ($urandom_range(0, 3) == 0) begin
				for (int j = eff; j < PAT_BITS; j++) begin
					if ($urandom_range(0, 2) == 0) begin
						send_item(CMD_LOAD, POS_W'(j), pick_symbol(), 1'b0);
					end
				end
			end

			strings = (phase == 0) ? 40 : $urandom_range(3, 10);
			for (int s = 0; s < strings; s++) begin
				send_string(eff, phase != 0 && $urandom_range(0, 11) == 0);
			end
			phase++;
		end

		wait_for_flags(5000);
		$display("Sent %0d items over %0d register settings (%0d writes), one long stall.",
			items_sent, settings_used, cfg_writes);
		$display("Checked %0d results, %0d of them matches, %0d mismatches.",
			tracker.results_seen, tracker.hits_seen, tracker.mismatch_count);
		if (tracker.mismatch_count == 0) begin
			$display("approximate_bitap_matcher regression: pass");
		end else begin
			$display("approximate_bitap_matcher regression: fail");
		end
		$finish;
	end

endmodule

@@ approximate_bitap_matcher.f @@
hw/rtl/bam_pkg.sv
hw/rtl/bam_ifs.sv
hw/rtl/bam_mask_mem.sv
hw/rtl/bam_level_unit.sv
hw/rtl/bam_out_fifo.sv
hw/rtl/approximate_bitap_matcher.sv
dv/approximate_bitap_matcher_test.sv
